### design/json_string_escaper_top_defines.svh
// Assertion macros used by the jse_emit escaper module.
// Needs a clk_i clock and an rst_ni active-low reset in the including module.
`ifndef JSON_STRING_ESCAPER_TOP_DEFINES_SVH
`define JSON_STRING_ESCAPER_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define JSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that an expression never holds outside reset.
`define JSE_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

### design/jse_pkg.sv
// Types and constants of the JSON string escaper.
// No dependencies; used by jse_encode, jse_emit and json_string_escaper_top.
package jse_pkg;

  localparam int unsigned MaxRun = 6;
  localparam int unsigned RunLenW = 3;

  typedef enum logic [1:0] {
    CMD_OPEN  = 2'd0,
    CMD_CHAR  = 2'd1,
    CMD_CLOSE = 2'd2
  } command_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChSlash     = 8'h2f;
  localparam logic [7:0] ChBackspace = 8'h08;
  localparam logic [7:0] ChNewline   = 8'h0a;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChReturn    = 8'h0d;
  localparam logic [7:0] ChLowerB    = 8'h62;
  localparam logic [7:0] ChLowerN    = 8'h6e;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChLowerR    = 8'h72;
  localparam logic [7:0] ChLowerU    = 8'h75;
  localparam logic [7:0] ChZero      = 8'h30;
  localparam logic [7:0] ChLowerA    = 8'h61;
  localparam logic [7:0] CtrlLimit   = 8'h20;

  typedef struct packed {
    logic [MaxRun-1:0][7:0] bytes;
    logic [RunLenW-1:0]     len;
  } run_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] nib);
    logic [7:0] d;
    if (nib < 4'd10) begin
      d = ChZero + {4'd0, nib};
    end else begin
      d = ChLowerA + {4'd0, nib} - 8'd10;
    end
    return d;
  endfunction

endpackage

### design/jse_encode.sv
// Escape encoder: turns one command and byte into a run of output bytes.
// Depends on jse_pkg.
module jse_encode (
  input  logic [1:0]    command_i,
  input  logic [7:0]    char_byte_i,
  input  logic          esc_high_i,
  output jse_pkg::run_t run_o
);

  logic [7:0] short_esc;

  always_comb begin
    unique case (char_byte_i)
      jse_pkg::ChBackspace: short_esc = jse_pkg::ChLowerB;
      jse_pkg::ChNewline:   short_esc = jse_pkg::ChLowerN;
      jse_pkg::ChTab:       short_esc = jse_pkg::ChLowerT;
      jse_pkg::ChReturn:    short_esc = jse_pkg::ChLowerR;
      jse_pkg::ChQuote,
      jse_pkg::ChBackslash,
      jse_pkg::ChSlash:     short_esc = char_byte_i;
      default:              short_esc = 8'd0;
    endcase
  end

  always_comb begin
    run_o = '0;
    unique case (jse_pkg::command_e'(command_i))
      jse_pkg::CMD_OPEN, jse_pkg::CMD_CLOSE: begin
        run_o.bytes[0] = jse_pkg::ChQuote;
        run_o.len      = 3'd1;
      end
      jse_pkg::CMD_CHAR: begin
        if (short_esc != 8'd0) begin
          run_o.bytes[0] = jse_pkg::ChBackslash;
          run_o.bytes[1] = short_esc;
          run_o.len      = 3'd2;
        end else if (char_byte_i < jse_pkg::CtrlLimit || (char_byte_i[7] && esc_high_i)) begin
          run_o.bytes[0] = jse_pkg::ChBackslash;
          run_o.bytes[1] = jse_pkg::ChLowerU;
          run_o.bytes[2] = jse_pkg::ChZero;
          run_o.bytes[3] = jse_pkg::ChZero;
          run_o.bytes[4] = jse_pkg::hex_digit(char_byte_i[7:4]);
          run_o.bytes[5] = jse_pkg::hex_digit(char_byte_i[3:0]);
          run_o.len      = 3'd6;
        end else begin
          run_o.bytes[0] = char_byte_i;
          run_o.len      = 3'd1;
        end
      end
      default: begin
        run_o = '0;
      end
    endcase
  end

endmodule

### design/jse_emit.sv
// Run register and result register: sends one byte of the current run per cycle.
// Depends on jse_pkg and json_string_escaper_top_defines.svh.
`include "json_string_escaper_top_defines.svh"
module jse_emit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  jse_pkg::run_t run_i,
  output logic          busy_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          last_of_run_o
);

  jse_pkg::run_t              run_q, run_d;
  logic [jse_pkg::RunLenW-1:0] idx_q, idx_d;
  logic                       active_q, active_d;
  logic                       valid_q;
  logic [7:0]                 byte_q;
  logic                       last_q;
  logic                       at_last;

  assign at_last = (idx_q == run_q.len - 3'd1);
  assign busy_o  = active_q && !at_last;

  always_comb begin
    run_d    = run_q;
    idx_d    = idx_q;
    active_d = active_q;
    if (load_i) begin
      run_d    = run_i;
      idx_d    = '0;
      active_d = (run_i.len != '0);
    end else if (active_q) begin
      if (at_last) begin
        active_d = 1'b0;
      end else begin
        idx_d = idx_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
      valid_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      idx_q    <= idx_d;
      valid_q  <= active_q;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q  <= run_d;
    byte_q <= run_q.bytes[idx_q];
    last_q <= at_last;
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign last_of_run_o = last_q;

  `JSE_ASSERT(a_load_only_when_free, load_i |-> !busy_o, "request loaded over a pending run")
  `JSE_ASSERT(a_idx_in_run, active_q |-> (idx_q < run_q.len), "byte index beyond run length")
  `JSE_ASSERT(a_strobe_from_run, valid_q |-> $past(active_q), "result strobe without a run")
  `JSE_ASSERT(a_last_ends_run, (valid_q && last_q) |-> $past(active_q && !busy_o), "last flag mid-run")
  `JSE_ASSERT_NEVER(a_busy_idle, busy_o && !active_q, "busy while no run is active")

endmodule

### design/json_string_escaper_top.sv
// JSON string escaper: a request (start with command_i, char_byte_i) is taken at a
// clock edge where start is high and busy is low. Plain bytes and the quotes for open
// and close keep busy low, so such requests go in every cycle. An escape holds busy
// until the run register, which sends one output byte per cycle, reaches its last byte.
// Each result byte passes the run register and then the result register and is shown
// for exactly one cycle with out_valid_o; the receiver cannot stall, and last_of_run_o
// marks the final byte of each request. An unused command code yields no result. The
// escape_high_bytes register (reset 1) is written through cfg_valid_i/cfg_ready_o; the
// user must write it while the block is idle, as the block itself does not enforce this.
// Depends on jse_pkg, jse_encode and jse_emit.
module json_string_escaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] command_i,
  input  logic [7:0] char_byte_i,
  output logic       out_valid_o,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic       cfg_data_i
);

  logic          esc_high_q;
  logic          load;
  jse_pkg::run_t run;

  assign cfg_ready_o = 1'b1;
  assign load        = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_high_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      esc_high_q <= cfg_data_i;
    end
  end

  jse_encode u_encode (
    .command_i   (command_i),
    .char_byte_i (char_byte_i),
    .esc_high_i  (esc_high_q),
    .run_o       (run)
  );

  jse_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (load),
    .run_i         (run),
    .busy_o        (busy),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for json_string_escaper_top: directed and random string requests,
// escaped bytes predicted in the bench and compared one by one. Depends on jse_pkg.
module tb_top;

  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int unsigned GapPct = 13;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainCycles = 12;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] ch;
  } request_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic [1:0] command_i = jse_pkg::CMD_OPEN;
  logic [7:0] char_byte_i = 8'h00;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_of_run_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic       cfg_data_i = 1'b0;

  request_t   pending_q[$];
  text_byte_t json_text_q[$];
  request_t   next_req;
  bit         escape_high = 1'b1;
  bit         no_gap = 1'b0;
  int unsigned err_count = 0;
  int unsigned req_count = 0;
  int unsigned byte_count = 0;
  int unsigned cfg_count = 0;
  int unsigned stall_cycles = 0;

  json_string_escaper_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .command_i     (command_i),
    .char_byte_i   (char_byte_i),
    .out_valid_o   (out_valid_o),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (err_count < 50) begin
      $display("[%0t] mismatch: %s got %02h want %02h", $time, what, got, want);
    end
    err_count++;
  endtask

  task automatic escape_request(input logic [1:0] cmd, input logic [7:0] ch);
    logic [7:0] seq[$];
    logic [7:0] short_code;
    string hex_digits = "0123456789abcdef";
    short_code = 8'h00;
    if (cmd == jse_pkg::CMD_OPEN || cmd == jse_pkg::CMD_CLOSE) begin
      seq.push_back(jse_pkg::ChQuote);
    end else if (cmd == jse_pkg::CMD_CHAR) begin
      case (ch)
        jse_pkg::ChBackspace: short_code = jse_pkg::ChLowerB;
        jse_pkg::ChNewline: short_code = jse_pkg::ChLowerN;
        jse_pkg::ChTab: short_code = jse_pkg::ChLowerT;
        jse_pkg::ChReturn: short_code = jse_pkg::ChLowerR;
        jse_pkg::ChQuote, jse_pkg::ChBackslash, jse_pkg::ChSlash: short_code = ch;
        default: short_code = 8'h00;
      endcase
      if (short_code != 8'h00) begin
        seq.push_back(jse_pkg::ChBackslash);
        seq.push_back(short_code);
      end else if (ch < jse_pkg::CtrlLimit || (ch[7] && escape_high)) begin
        seq.push_back(jse_pkg::ChBackslash);
        seq.push_back(jse_pkg::ChLowerU);
        seq.push_back(jse_pkg::ChZero);
        seq.push_back(jse_pkg::ChZero);
        seq.push_back(hex_digits[ch[7:4]]);
        seq.push_back(hex_digits[ch[3:0]]);
      end else begin
        seq.push_back(ch);
      end
    end
    foreach (seq[i]) begin
      json_text_q.push_back('{ch: seq[i], last: (i == seq.size() - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        escape_request(command_i, char_byte_i);
        req_count++;
      end
      if (!start || !busy) begin
        if (pending_q.size() != 0 && (no_gap || $urandom_range(0, 99) >= GapPct)) begin
          next_req = pending_q.pop_front();
          start <= 1'b1;
          command_i <= next_req.cmd;
          char_byte_i <= next_req.ch;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      byte_count++;
      if (json_text_q.size() == 0) begin
        report_mismatch("unexpected byte", out_byte_o, 8'h00);
      end else begin
        if (out_byte_o !== json_text_q[0].ch) begin
          report_mismatch("out_byte", out_byte_o, json_text_q[0].ch);
        end
        if (last_of_run_o !== json_text_q[0].last) begin
          report_mismatch("last_of_run", {7'd0, last_of_run_o}, {7'd0, json_text_q[0].last});
        end
        void'(json_text_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || out_valid_o || (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Timeout after %0d cycles without progress", StallLimit);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic push_req(input logic [1:0] cmd, input logic [7:0] ch);
    pending_q.push_back('{cmd: cmd, ch: ch});
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || start || json_text_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  task automatic write_escape_high(input bit value);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_data_i <= value;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    escape_high = value;
    cfg_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] random_char();
    logic [7:0] specials[7] = '{jse_pkg::ChBackspace, jse_pkg::ChNewline,
                                jse_pkg::ChTab, jse_pkg::ChReturn,
                                jse_pkg::ChQuote, jse_pkg::ChBackslash,
                                jse_pkg::ChSlash};
    logic [7:0] ch;
    case ($urandom_range(0, 4))
      0: ch = 8'($urandom_range(8'h20, 8'h7e));
      1: ch = specials[$urandom_range(0, 6)];
      2: ch = 8'($urandom_range(8'h00, 8'h1f));
      3: ch = 8'($urandom_range(8'h80, 8'hff));
      default: ch = 8'($urandom);
    endcase
    return ch;
  endfunction

  task automatic push_random(input int unsigned count);
    int unsigned added;
    int unsigned len;
    added = 0;
    while (added < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req(2'($urandom_range(0, 3)), 8'($urandom));
        added++;
      end else begin
        len = $urandom_range(0, 12);
        push_req(jse_pkg::CMD_OPEN, 8'($urandom));
        repeat (len) push_req(jse_pkg::CMD_CHAR, random_char());
        push_req(jse_pkg::CMD_CLOSE, 8'($urandom));
        added += len + 2;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_req(jse_pkg::CMD_OPEN, 8'h00);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChBackspace);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChNewline);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChTab);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChReturn);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChQuote);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChBackslash);
    push_req(jse_pkg::CMD_CHAR, jse_pkg::ChSlash);
    push_req(jse_pkg::CMD_CHAR, 8'h00);
    push_req(jse_pkg::CMD_CHAR, 8'h0c);
    push_req(jse_pkg::CMD_CHAR, 8'h1f);
    push_req(jse_pkg::CMD_CHAR, 8'h7f);
    push_req(jse_pkg::CMD_CHAR, 8'h20);
    push_req(jse_pkg::CMD_CHAR, 8'h41);
    push_req(jse_pkg::CMD_CHAR, 8'h80);
    push_req(jse_pkg::CMD_CHAR, 8'hff);
    push_req(CmdUnused, 8'h5a);
    push_req(jse_pkg::CMD_CLOSE, 8'hff);
    push_req(CmdUnused, 8'hff);
    push_req(jse_pkg::CMD_OPEN, 8'hff);
    push_req(jse_pkg::CMD_CLOSE, 8'h00);

    write_escape_high(1'b0);
    push_req(jse_pkg::CMD_CHAR, 8'h80);
    push_req(jse_pkg::CMD_CHAR, 8'ha5);
    push_req(jse_pkg::CMD_CHAR, 8'hff);
    push_random(60);
    wait_drained();
    push_random(60);

    write_escape_high(1'b1);
    no_gap = 1'b1;
    push_random(150);
    wait_drained();
    no_gap = 1'b0;

    write_escape_high(1'b0);
    push_random(160);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d requests and %0d output bytes over %0d register writes,",
             req_count, byte_count, cfg_count);
    $display("with high bytes both escaped and passed through, and %0d errors.", err_count);
    if (err_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
